// File: hw/rtl/ctdt_pkg.sv
// ----------------------------------------------------------------------------
// ctdt_pkg
// Shared types and constants for the civil time to day/tick word converter.
// ----------------------------------------------------------------------------
`default_nettype none

package ctdt_pkg;

   // epoch of the year walk and its residue modulo 25
   localparam logic [11:0] YearBase      = 12'd1970;
   localparam logic [4:0]  YearBaseMod25 = 5'd20;
   localparam logic [4:0]  Div25         = 5'd25;
   localparam logic [4:0]  Div25Last     = 5'd24;

   // floor(v / 25) = (v * Recip25) >> Recip25Shift, exact for v < 43690
   localparam logic [12:0] Recip25      = 13'd5243;
   localparam int unsigned Recip25Shift = 17;

   // floor(v / 1000) = (v * Recip1000) >> Recip1000Shift, exact for v < 493000
   localparam logic [18:0] Recip1000      = 19'd268436;
   localparam int unsigned Recip1000Shift = 28;

   localparam logic [8:0]  DaysPerYear  = 9'd365;
   localparam logic [5:0]  MinPerHour   = 6'd60;
   localparam logic [5:0]  SecPerMin    = 6'd60;
   localparam logic [8:0]  TicksPerSec  = 9'd300;
   localparam logic [7:0]  MsBias       = 8'd150;
   localparam logic [3:0]  MonthsInYear = 4'd12;
   localparam logic [3:0]  MonthFeb     = 4'd2;

   // 1900 offset minus one, folding in the day-of-month base of one
   localparam logic [31:0] DayOffset = 32'd25566;

   localparam int unsigned DaysW  = 20;
   localparam int unsigned TicksW = 26;
   localparam int unsigned StampW = 64;

   typedef struct packed {
      logic load;
      logic prep_a;
      logic prep_b;
      logic prep_c;
      logic year_step;
      logic month_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic year_done;
      logic month_done;
   } sts_type;

   function automatic logic [4:0] month_len(input logic [3:0] idx);
      logic [4:0] len;
      unique case (idx)
         4'd0:    len = 5'd31;
         4'd1:    len = 5'd28;
         4'd2:    len = 5'd31;
         4'd3:    len = 5'd30;
         4'd4:    len = 5'd31;
         4'd5:    len = 5'd30;
         4'd6:    len = 5'd31;
         4'd7:    len = 5'd31;
         4'd8:    len = 5'd30;
         4'd9:    len = 5'd31;
         4'd10:   len = 5'd30;
         4'd11:   len = 5'd31;
         default: len = 5'd0;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ctdt_if.sv
// ----------------------------------------------------------------------------
// ctdt_if
// Valid/ready channels for civil time requests and packed stamp responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface ctdt_req_if;
   logic        valid;
   logic        ready;
   logic [11:0] year;
   logic [3:0]  month;
   logic [4:0]  day_of_month;
   logic [4:0]  hour;
   logic [5:0]  minute;
   logic [5:0]  second;
   logic [9:0]  millisecond;

   modport source (
      output valid, year, month, day_of_month, hour, minute, second, millisecond,
      input  ready
   );
   modport sink (
      input  valid, year, month, day_of_month, hour, minute, second, millisecond,
      output ready
   );
endinterface

interface ctdt_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] packed_stamp;

   modport source (output valid, packed_stamp, input ready);
   modport sink   (input valid, packed_stamp, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/ctdt_ctrl.sv
// ----------------------------------------------------------------------------
// ctdt_ctrl
// Sequencer: load, three prep steps, year walk, month walk, finish, hand off.
// ----------------------------------------------------------------------------
`default_nettype none

module ctdt_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire ctdt_pkg::sts_type sts,
   input  wire logic              out_free,
   output ctdt_pkg::cmd_type      cmd,
   output logic                   out_load
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_PREP_A = 3'd1;
   localparam logic [2:0] ST_PREP_B = 3'd2;
   localparam logic [2:0] ST_PREP_C = 3'd3;
   localparam logic [2:0] ST_YEARS  = 3'd4;
   localparam logic [2:0] ST_MONTHS = 3'd5;
   localparam logic [2:0] ST_FINISH = 3'd6;
   localparam logic [2:0] ST_HOLD   = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      out_load = 1'b0;
      in_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.load = 1'b1;
               state_in = ST_PREP_A;
            end
         end
         ST_PREP_A: begin
            cmd.prep_a = 1'b1;
            state_in   = ST_PREP_B;
         end
         ST_PREP_B: begin
            cmd.prep_b = 1'b1;
            state_in   = ST_PREP_C;
         end
         ST_PREP_C: begin
            cmd.prep_c = 1'b1;
            state_in   = ST_YEARS;
         end
         ST_YEARS: begin
            if (sts.year_done) begin
               state_in = ST_MONTHS;
            end else begin
               cmd.year_step = 1'b1;
            end
         end
         ST_MONTHS: begin
            if (sts.month_done) begin
               state_in = ST_FINISH;
            end else begin
               cmd.month_step = 1'b1;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_HOLD;
         end
         ST_HOLD: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/ctdt_dp.sv
// ----------------------------------------------------------------------------
// ctdt_dp
// Datapath: day counter walk, leap tests, tick arithmetic, stamp register.
// ----------------------------------------------------------------------------
`default_nettype none

module ctdt_dp (
   input  wire logic              clock,
   input  wire ctdt_pkg::cmd_type cmd,
   input  wire logic [11:0]       year,
   input  wire logic [3:0]        month,
   input  wire logic [4:0]        day_of_month,
   input  wire logic [4:0]        hour,
   input  wire logic [5:0]        minute,
   input  wire logic [5:0]        second,
   input  wire logic [9:0]        millisecond,
   output ctdt_pkg::sts_type      sts,
   output logic [63:0]            stamp
);

   logic [11:0] year_ff;
   logic [3:0]  month_ff;
   logic [4:0]  mday_ff;
   logic [4:0]  hour_ff;
   logic [5:0]  minute_ff;
   logic [5:0]  second_ff;
   logic [9:0]  msec_ff;

   logic [11:0]                  y_ff;
   logic [4:0]                   y25_ff;
   logic [3:0]                   m_ff;
   logic [ctdt_pkg::DaysW-1:0]   days_ff;
   logic [7:0]                   q25_ff;
   logic                         leap_year_ff;
   logic [16:0]                  tm_ff;
   logic [18:0]                  msx_ff;
   logic [37:0]                  msp_ff;
   logic [ctdt_pkg::TicksW-1:0]  ticks_ff;
   logic [63:0]                  stamp_ff;

   logic [24:0] q25_prod;
   logic [11:0] rem25;
   logic        leap_y;
   logic [4:0]  m_next;
   logic [31:0] day_word;
   logic        leap_add;

   assign q25_prod = 25'(year_ff) * 25'(ctdt_pkg::Recip25);
   assign rem25    = year_ff - 12'(q25_ff) * 12'(ctdt_pkg::Div25);
   assign leap_y   = (y_ff[1:0] == 2'd0) && ((y25_ff != 5'd0) || (y_ff[3:0] == 4'd0));
   assign m_next   = {1'b0, m_ff} + 5'd1;
   assign leap_add = (month_ff > ctdt_pkg::MonthFeb) && leap_year_ff;
   assign day_word = 32'(days_ff) + 32'(mday_ff) + ctdt_pkg::DayOffset + 32'(leap_add);

   assign sts.year_done  = (y_ff >= year_ff);
   assign sts.month_done = (m_next >= {1'b0, month_ff}) || (m_ff == ctdt_pkg::MonthsInYear);
   assign stamp          = stamp_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         year_ff   <= year;
         month_ff  <= month;
         mday_ff   <= day_of_month;
         hour_ff   <= hour;
         minute_ff <= minute;
         second_ff <= second;
         msec_ff   <= millisecond;
         y_ff      <= ctdt_pkg::YearBase;
         y25_ff    <= ctdt_pkg::YearBaseMod25;
         m_ff      <= 4'd0;
         days_ff   <= '0;
      end
      if (cmd.prep_a) begin
         q25_ff <= q25_prod[ctdt_pkg::Recip25Shift +: 8];
         tm_ff  <= 17'(11'(hour_ff) * 11'(ctdt_pkg::MinPerHour) + 11'(minute_ff));
         msx_ff <= (msec_ff == 10'd0) ? 19'd0 :
                   19'(19'(msec_ff) * 19'(ctdt_pkg::TicksPerSec) - 19'(ctdt_pkg::MsBias));
      end
      if (cmd.prep_b) begin
         leap_year_ff <= (year_ff[1:0] == 2'd0) &&
                         ((rem25 != 12'd0) || (year_ff[3:0] == 4'd0));
         tm_ff        <= tm_ff * 17'(ctdt_pkg::SecPerMin) + 17'(second_ff);
         msp_ff       <= 38'(msx_ff) * 38'(ctdt_pkg::Recip1000);
      end
      if (cmd.prep_c) begin
         ticks_ff <= ctdt_pkg::TicksW'(tm_ff) * ctdt_pkg::TicksW'(ctdt_pkg::TicksPerSec) +
                     ctdt_pkg::TicksW'(msp_ff[ctdt_pkg::Recip1000Shift +: 10]);
      end
      if (cmd.year_step) begin
         days_ff <= days_ff + ctdt_pkg::DaysW'(ctdt_pkg::DaysPerYear) + ctdt_pkg::DaysW'(leap_y);
         y_ff    <= y_ff + 12'd1;
         y25_ff  <= (y25_ff == ctdt_pkg::Div25Last) ? 5'd0 : y25_ff + 5'd1;
      end
      if (cmd.month_step) begin
         days_ff <= days_ff + ctdt_pkg::DaysW'(ctdt_pkg::month_len(m_ff));
         m_ff    <= m_next[3:0];
      end
      if (cmd.finish) begin
         stamp_ff <= {day_word, 6'd0, ticks_ff};
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/civil_time_to_day_tick_word.sv
// ----------------------------------------------------------------------------
// civil_time_to_day_tick_word
// Civil date and time to packed word: days since 1900 above, 1/300 s ticks below.
// ----------------------------------------------------------------------------
// The year walk adds one year per cycle through the day counter, from 1970 up to
//   the requested year; the month walk then adds the months before the requested
//   one, at most 12. A new request is taken only after the previous stamp has
//   been handed to the response register, which may wait on the consumer.
// Reset: synchronous, active high; clears sequencer and response valid only.
// ----------------------------------------------------------------------------
`default_nettype none

module civil_time_to_day_tick_word (
   input  wire logic   clock,
   input  wire logic   reset,
   ctdt_req_if.sink    req_ch,
   ctdt_rsp_if.source  rsp_ch
);

   ctdt_pkg::cmd_type cmd;
   ctdt_pkg::sts_type sts;
   logic              out_load;
   logic              out_free;
   logic [63:0]       dp_stamp;

   // response holding register: parts the request side from a stalled consumer
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [63:0] rsp_stamp_ff;

   // slot is free when empty or when the waiting beat leaves this cycle
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // sequencer: walks years, then months, then hands the stamp off
   ctdt_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_ch.valid),
      .in_ready (req_ch.ready),
      .sts      (sts),
      .out_free (out_free),
      .cmd      (cmd),
      .out_load (out_load)
   );

   // arithmetic: day count, leap tests, tick sum
   ctdt_dp u_dp (
      .clock        (clock),
      .cmd          (cmd),
      .year         (req_ch.year),
      .month        (req_ch.month),
      .day_of_month (req_ch.day_of_month),
      .hour         (req_ch.hour),
      .minute       (req_ch.minute),
      .second       (req_ch.second),
      .millisecond  (req_ch.millisecond),
      .sts          (sts),
      .stamp        (dp_stamp)
   );

   // hold the beat until taken; refill on the same cycle it drains
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_stamp_ff <= dp_stamp;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.packed_stamp = rsp_stamp_ff;

   // at most one datapath operation per cycle
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.prep_a, cmd.prep_b, cmd.prep_c,
                cmd.year_step, cmd.month_step, cmd.finish}))
      else $error("datapath commands overlap");

   // never overwrite a response beat that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> out_free)
      else $error("response register overwritten");

   // a fresh request cannot produce a response in the next cycle
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !out_load)
      else $error("response loaded too early");

   // requests are only taken while no year, month or finish step is running
   a_idle_accept: assert property (@(posedge clock) disable iff (reset)
      req_ch.ready |-> !(cmd.year_step || cmd.month_step || cmd.finish))
      else $error("request taken while busy");

endmodule

`default_nettype wire
